/* hdl/bssa_pkg.sv */
// Shared types and constants for the bitmap slab slot allocator.
// Payload structs, status and request codes, register indexes, and the
// controller/datapath command and status bundles. No dependencies.
package bssa_pkg;

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_FREED   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // configuration port
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 7;
  localparam logic [CFG_IW-1:0] CFG_SLOTS = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_LIMIT = 1'b1;
  localparam logic [6:0] SLOTS_RST = 7'd64;
  localparam logic [4:0] LIMIT_RST = 5'd16;

  typedef struct packed {
    logic       req_type;
    logic [3:0] free_slab;
    logic [5:0] free_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slab_index;
    logic [5:0] slot_index;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rd_free;
    logic free_wr;
    logic ld_ign;
    logic ld_full;
    logic grow;
    logic rd_cur;
    logic scan;
    logic alloc_wr;
    logic cur_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_is_free;
    logic free_bad;
    logic cur_past;
    logic can_grow;
    logic found;
    logic out_room;
  } sts_t;

endpackage

/* hdl/bitmap_slab_slot_allocator_top.sv */
// Top level of the bitmap slab slot allocator: bssa_ctrl plus bssa_dp.
// Depends on bssa_pkg for payload structs and control bundles.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | bssa_pkg::in_item_t
//   out_    | output    | out_valid/out_stall| bssa_pkg::out_item_t
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One request at a time. A free goes through check and write states to the result
// register (only the check when out of range). An allocate runs a read, search
// and pick loop, repeated for every full slab stepped over, with a grow step for
// every slab brought into use (a pool that is full ends at the check), on the
// single bitmap memory read port.
// Reset (synchronous) clears the per-slab valid bits at once; no clearing pass.
// A stalled result waits in the output register while the next request runs.
module bitmap_slab_slot_allocator_top #(
  parameter int MAX_SLABS          = 16,
  parameter int SLOT_BITS_PER_SLAB = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bssa_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bssa_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bssa_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bssa_pkg::out_item_t         out_data
);

  bssa_pkg::cmd_t cmd;
  bssa_pkg::sts_t sts;

  bssa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bssa_dp #(
    .MAX_SLABS          (MAX_SLABS),
    .SLOT_BITS_PER_SLAB (SLOT_BITS_PER_SLAB)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* hdl/bssa_ctrl.sv */
// Controller for the slab slot allocator: one-hot state machine that
// sequences free and allocate requests. Uses bssa_pkg cmd_t / sts_t.
module bssa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bssa_pkg::sts_t sts,
  output bssa_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_FREE_CHK  = 7'b0000010,
    S_FREE_WR   = 7'b0000100,
    S_ALLOC_CHK = 7'b0001000,
    S_SCAN      = 7'b0010000,
    S_PICK      = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_is_free ? S_FREE_CHK : S_ALLOC_CHK;
        end
      end
      S_FREE_CHK: begin
        if (sts.free_bad) begin
          cmd.ld_ign = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_free = 1'b1;
          state_nxt   = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_ALLOC_CHK: begin
        if (sts.cur_past) begin
          // pointer ran off the slabs in use: bring one more in, or give up
          if (sts.can_grow) begin
            cmd.grow = 1'b1;
          end else begin
            cmd.ld_full = 1'b1;
            state_nxt   = S_DONE;
          end
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (sts.found) begin
          cmd.alloc_wr = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.cur_inc = 1'b1;
          state_nxt   = S_ALLOC_CHK;
        end
      end
      S_DONE: begin
        if (sts.out_room) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/bssa_dp.sv */
// Datapath for the slab slot allocator: config registers, bitmap memory
// with per-slab valid bits, two-step free-slot search, output register.
// Driven by bssa_ctrl through bssa_pkg cmd_t / sts_t.
module bssa_dp #(
  parameter int MAX_SLABS          = 16,
  parameter int SLOT_BITS_PER_SLAB = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bssa_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [bssa_pkg::CFG_DW-1:0]   cfg_wdata,
  input  bssa_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bssa_pkg::out_item_t           out_data,
  input  bssa_pkg::cmd_t                cmd,
  output bssa_pkg::sts_t                sts
);

  localparam int SW   = $clog2(MAX_SLABS + 1);
  localparam int AW   = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int BW   = SLOT_BITS_PER_SLAB;
  localparam int IW   = (BW > 1) ? $clog2(BW) : 1;
  localparam int NGRP = (BW + 7) / 8;
  localparam int PADW = NGRP * 8;
  localparam int CW   = (SW > 5) ? SW : 5;

  // configuration
  logic [6:0] slots_per_slab_r;
  logic [4:0] slab_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_per_slab_r <= bssa_pkg::SLOTS_RST;
      slab_limit_r     <= bssa_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bssa_pkg::CFG_SLOTS: slots_per_slab_r <= cfg_wdata[6:0];
        bssa_pkg::CFG_LIMIT: slab_limit_r     <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  logic [6:0]    eff_slots;
  logic [CW-1:0] lim_ext;
  logic [CW-1:0] eff_lim;

  always_comb begin
    if (slots_per_slab_r == 7'd0) begin
      eff_slots = 7'd1;
    end else if (slots_per_slab_r > 7'(BW)) begin
      eff_slots = 7'(BW);
    end else begin
      eff_slots = slots_per_slab_r;
    end
    lim_ext = CW'(slab_limit_r);
    if (lim_ext == '0) begin
      eff_lim = CW'(1);
    end else if (lim_ext > CW'(MAX_SLABS)) begin
      eff_lim = CW'(MAX_SLABS);
    end else begin
      eff_lim = lim_ext;
    end
  end

  // request and slab pointers
  bssa_pkg::in_item_t req_r;
  logic [SW-1:0]      cur_r, cur_nxt;
  logic [SW-1:0]      in_use_r, in_use_nxt;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    cur_nxt    = cur_r;
    in_use_nxt = in_use_r;
    if (cmd.cur_inc) begin
      cur_nxt = cur_r + SW'(1);
    end else if (cmd.free_wr && (CW'(cur_r) > CW'(req_r.free_slab))) begin
      cur_nxt = SW'(req_r.free_slab);
    end
    if (cmd.grow) begin
      in_use_nxt = in_use_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      in_use_r <= SW'(1);
    end else begin
      cur_r    <= cur_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  // bitmap memory; a slab whose valid bit is clear reads as all free
  logic [BW-1:0]        mem [MAX_SLABS];
  logic [MAX_SLABS-1:0] valid_r;
  logic [BW-1:0]        rd_data_r;
  logic                 rd_valid_r;
  logic [AW-1:0]        free_addr, cur_addr, rd_addr, wr_addr;
  logic                 mem_re, mem_we;
  logic [BW-1:0]        wr_data;
  logic [BW-1:0]        eff_bits;
  logic [IW-1:0]        pick_slot;
  logic [IW-1:0]        free_slot_ix;

  assign free_addr    = AW'(req_r.free_slab);
  assign cur_addr     = AW'(cur_r);
  assign free_slot_ix = IW'(req_r.free_slot);
  assign mem_re       = cmd.rd_cur | cmd.rd_free;
  assign rd_addr      = cmd.rd_free ? free_addr : cur_addr;
  assign mem_we       = cmd.alloc_wr | cmd.free_wr;
  assign wr_addr      = cmd.free_wr ? free_addr : cur_addr;
  assign eff_bits     = rd_valid_r ? rd_data_r : '0;
  assign wr_data      = cmd.free_wr ? (eff_bits & ~(BW'(1) << free_slot_ix))
                                    : (eff_bits | (BW'(1) << pick_slot));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.grow) begin
        valid_r[AW'(in_use_r)] <= 1'b0;
      end
      if (mem_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // free-slot search: lowest zero per 8-bit group, then lowest group
  logic [PADW-1:0] pad_bits;
  logic [NGRP-1:0] grp_free;
  logic [2:0]      grp_idx [NGRP];
  logic [NGRP-1:0] grp_free_r;
  logic [2:0]      grp_idx_r [NGRP];

  always_comb begin
    pad_bits = '1;
    for (int i = 0; i < BW; i++) begin
      pad_bits[i] = eff_bits[i] | (7'(i) >= eff_slots);
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_free[g] = ~&pad_bits[g*8 +: 8];
      grp_idx[g]  = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (!pad_bits[g*8 + b]) begin
          grp_idx[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      grp_free_r <= grp_free;
      grp_idx_r  <= grp_idx;
    end
  end

  logic       found;
  logic [6:0] pick_ix;

  always_comb begin
    found   = 1'b0;
    pick_ix = 7'd0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        found   = 1'b1;
        pick_ix = 7'(g * 8) + 7'(grp_idx_r[g]);
      end
    end
  end

  assign pick_slot = IW'(pick_ix);

  // result hold and output register
  bssa_pkg::out_item_t res_r;
  bssa_pkg::out_item_t out_data_r;
  logic                out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.alloc_wr) begin
      res_r.status     <= bssa_pkg::ST_ALLOC;
      res_r.slab_index <= 4'(cur_r);
      res_r.slot_index <= 6'(pick_slot);
    end else if (cmd.free_wr) begin
      res_r.status     <= bssa_pkg::ST_FREED;
      res_r.slab_index <= req_r.free_slab;
      res_r.slot_index <= req_r.free_slot;
    end else if (cmd.ld_full) begin
      res_r.status     <= bssa_pkg::ST_FULL;
      res_r.slab_index <= '0;
      res_r.slot_index <= '0;
    end else if (cmd.ld_ign) begin
      res_r.status     <= bssa_pkg::ST_IGNORED;
      res_r.slab_index <= '0;
      res_r.slot_index <= '0;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.in_is_free = (in_data.req_type == bssa_pkg::REQ_FREE);
  assign sts.free_bad   = (CW'(req_r.free_slab) >= CW'(in_use_r)) ||
                          (7'(req_r.free_slot) >= eff_slots);
  assign sts.cur_past   = (cur_r >= in_use_r);
  assign sts.can_grow   = (CW'(in_use_r) < eff_lim);
  assign sts.found      = found;
  assign sts.out_room   = !out_valid_r || !out_stall;

endmodule

/* test/bssa_checker.sv */
// Result checker for the bitmap slab slot allocator: tracks register writes,
// predicts one result per accepted request and compares every result transfer.
// Depends on bssa_pkg for payload structs, status codes and register indexes.
module bssa_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bssa_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bssa_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  bssa_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  bssa_pkg::out_item_t         out_data,
  output int                          mismatches,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLABS = 16;
  localparam int NBITS  = 64;

  logic [63:0]         occ [NSLABS];
  logic [4:0]          cur_slab;
  logic [4:0]          slabs_used;
  logic [6:0]          slots_reg;
  logic [4:0]          limit_reg;
  bssa_pkg::out_item_t grants_due [$];

  task automatic predict_grant(input bssa_pkg::in_item_t req,
                               output bssa_pkg::out_item_t res);
    int  eslots;
    int  elimit;
    int  step;
    int  i;
    bit  done;
    eslots = (slots_reg == 0) ? 1 : (slots_reg > NBITS) ? NBITS : int'(slots_reg);
    elimit = (limit_reg == 0) ? 1 : (limit_reg > NSLABS) ? NSLABS : int'(limit_reg);
    res = '0;
    if (req.req_type == bssa_pkg::REQ_FREE) begin
      if (req.free_slab >= slabs_used || req.free_slot >= eslots) begin
        res.status = bssa_pkg::ST_IGNORED;
      end else begin
        // no check that the slot was taken
        occ[req.free_slab][req.free_slot] = 1'b0;
        if (cur_slab > req.free_slab) cur_slab = {1'b0, req.free_slab};
        res.status     = bssa_pkg::ST_FREED;
        res.slab_index = req.free_slab;
        res.slot_index = req.free_slot;
      end
    end else begin
      res.status = bssa_pkg::ST_FULL;
      done = 1'b0;
      step = 0;
      while (!done && step <= 2 * NSLABS + 1) begin
        if (cur_slab >= slabs_used) begin
          // pointer past the slabs in use: bring one more in, if allowed
          if (slabs_used < elimit) begin
            if (slabs_used < NSLABS) occ[slabs_used[3:0]] = '0;
            slabs_used = slabs_used + 5'd1;
          end else begin
            done = 1'b1;
          end
        end else begin
          for (i = 0; i < eslots && !done; i++) begin
            if (!occ[cur_slab[3:0]][i]) begin
              occ[cur_slab[3:0]][i] = 1'b1;
              res.status     = bssa_pkg::ST_ALLOC;
              res.slab_index = cur_slab[3:0];
              res.slot_index = 6'(i);
              done = 1'b1;
            end
          end
          if (!done) cur_slab = cur_slab + 5'd1;
        end
        step++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    bssa_pkg::out_item_t want;
    if (!rst_n) begin
      for (int k = 0; k < NSLABS; k++) occ[k] = '0;
      cur_slab   = '0;
      slabs_used = 5'd1;
      slots_reg  = bssa_pkg::SLOTS_RST;
      limit_reg  = bssa_pkg::LIMIT_RST;
      grants_due.delete();
      pending    = 0;
    end else begin
      // a result never belongs to a request taken on the same edge
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none outstanding: status %0d slab %0d slot %0d",
                     $realtime, out_data.status, out_data.slab_index, out_data.slot_index);
        end else begin
          want = grants_due.pop_front();
          if (out_data.status != want.status || out_data.slab_index != want.slab_index ||
              out_data.slot_index != want.slot_index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected status %0d slab %0d slot %0d, got %0d %0d %0d",
                       $realtime, want.status, want.slab_index, want.slot_index,
                       out_data.status, out_data.slab_index, out_data.slot_index);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == bssa_pkg::CFG_SLOTS) slots_reg = cfg_wdata;
        else if (cfg_index == bssa_pkg::CFG_LIMIT) limit_reg = cfg_wdata[4:0];
      end
      if (in_valid && !in_stall) begin
        predict_grant(in_data, want);
        grants_due = {grants_due, want};
      end
      pending = grants_due.size();
    end
  end

endmodule

/* test/tb.sv */
// Testbench top for the bitmap slab slot allocator: clock, reset, register
// writes, request stimulus and result stalls; bssa_checker does the checking.
// Depends on bssa_pkg, bitmap_slab_slot_allocator_top and bssa_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [bssa_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [bssa_pkg::CFG_DW-1:0] cfg_wdata = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  bssa_pkg::in_item_t          in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  bssa_pkg::out_item_t         out_data;
  int                          mismatches;
  int                          pending;
  bit                          calm = 1'b0;

  always #5 clk = ~clk;

  bitmap_slab_slot_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  bssa_checker audit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // entered just after a falling edge; returns just after the one following the transfer
  task automatic send_req(input logic kind, input logic [3:0] slab, input logic [5:0] slot);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data.req_type  <= kind;
    in_data.free_slab <= slab;
    in_data.free_slot <= slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_regs(input logic [6:0] slots, input logic [6:0] limit);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= bssa_pkg::CFG_SLOTS;
    cfg_wdata <= slots;
    @(negedge clk);
    cfg_index <= bssa_pkg::CFG_LIMIT;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
    calm   <= ($urandom_range(0, 3) == 0);
  endtask

  // mostly allocates and frees of slots likely in use, some frees anywhere
  task automatic run_mix(input int n, input int alloc_pct, input int slab_hi, input int slot_hi);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
        send_req(bssa_pkg::REQ_ALLOC, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
      else if (r < alloc_pct + 8)
        send_req(bssa_pkg::REQ_FREE, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
      else
        send_req(bssa_pkg::REQ_FREE, 4'($urandom_range(0, slab_hi)),
                 6'($urandom_range(0, slot_hi)));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one slab in use
    send_req(bssa_pkg::REQ_FREE, 4'd1, 6'd0);
    send_req(bssa_pkg::REQ_FREE, 4'd0, 6'd63);
    send_req(bssa_pkg::REQ_FREE, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_ALLOC, 4'd15, 6'd63);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_FREE, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);

    // one slot per slab, two slabs: grow, then pool full
    set_regs(7'd1, 7'd2);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_FREE, 4'd1, 6'd0);
    send_req(bssa_pkg::REQ_FREE, 4'd0, 6'd1);
    send_req(bssa_pkg::REQ_FREE, 4'd15, 6'd63);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);

    // zero values clamp to one; limit now below the slabs in use
    set_regs(7'd0, 7'd0);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_FREE, 4'd1, 6'd0);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_FREE, 4'd2, 6'd0);

    // values above range clamp to the maximum
    set_regs(7'd127, 7'd31);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);
    send_req(bssa_pkg::REQ_ALLOC, 4'd0, 6'd0);

    set_regs(7'd64, 7'd2);
    run_mix(180, 90, 1, 63);
    set_regs(7'd3, 7'd3);
    run_mix(70, 65, 2, 2);
    set_regs(7'd5, 7'd100);
    run_mix(70, 65, 3, 4);
    set_regs(7'd1, 7'd16);
    run_mix(60, 70, 15, 0);
    set_regs(7'd2, 7'd16);
    run_mix(70, 60, 15, 1);
    set_regs(7'd127, 7'd31);
    run_mix(150, 60, 15, 63);
    set_regs(7'd4, 7'd0);
    run_mix(70, 60, 15, 3);
    set_regs(7'd65, 7'd17);
    run_mix(60, 55, 15, 63);
    set_regs(7'd7, 7'd9);
    run_mix(90, 60, 15, 6);

    wait_idle();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // result side: a fresh stall length for every result
  initial begin : result_sink
    int w;
    forever begin
      @(negedge clk);
      w = calm ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
